// ===== sv/mhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// Min-heap priority queue package
// Shared sizes, entry layout, status and action codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

   // Queue sizing and field widths.
   localparam int CAPACITY   = 256;
   localparam int ID_BITS    = 8;
   localparam int KEY_BITS   = 32;
   localparam int ADDR_BITS  = $clog2(CAPACITY);
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);
   localparam int STATUS_BITS = 2;

   // One heap entry as held in the store.
   typedef struct packed {
      logic [ID_BITS-1:0]  id;
      logic [KEY_BITS-1:0] key;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   // Request actions.
   localparam logic ACTION_PUSH = 1'b0;
   localparam logic ACTION_POP  = 1'b1;

   // Result status codes.
   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_POP_EMPTY = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_PUSH_FULL = 2'd2;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PU_CHK,
      ST_PU_CMP,
      ST_PO_ROOT,
      ST_PO_LAST,
      ST_PO_CHK,
      ST_PO_LEFT,
      ST_PO_RIGHT,
      ST_PO_MOVE,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== sv/mhpq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined at reset.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

// ===== sv/min_heap_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// Min-heap priority queue core
// Binary min-heap of (id, key) entries with push and pop-minimum requests.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake         | Payload
//   --------+-----------+-------------------+----------------------------------
//   req     | in        | req_valid/stall   | action, item_id, key
//   rsp     | out       | rsp_valid/stall   | out_id, out_key, status,
//           |           |                   | count_after, now_empty
//
// A push climbs from the next free slot toward the root, moving each parent
// with a larger key down into the hole; a pop takes the root as the minimum
// and sinks the last entry from the root, pulling the smaller child up while
// its key is strictly smaller. The cost is set by the single read port of the
// heap RAM and the one key comparator that every step shares. Error requests
// go straight to the response without touching the heap.
// Reset is synchronous and empties the queue; the store is never cleared.
// The next request beat is taken in the cycle after the response is loaded, even
// while that response beat still waits under rsp_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module min_heap_priority_queue_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_action,
   input  wire logic [mhpq_pkg::ID_BITS-1:0]      req_item_id,
   input  wire logic [mhpq_pkg::KEY_BITS-1:0]     req_key,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [mhpq_pkg::ID_BITS-1:0]      rsp_out_id,
   output logic      [mhpq_pkg::KEY_BITS-1:0]     rsp_out_key,
   output logic      [mhpq_pkg::STATUS_BITS-1:0]  rsp_status,
   output logic      [mhpq_pkg::COUNT_BITS-1:0]   rsp_count_after,
   output logic                                   rsp_now_empty
);

   import mhpq_pkg::*;

   localparam int CHILD_BITS = ADDR_BITS + 2;

   // Control state.
   state_type              state_ff, state_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // Working payload.
   logic [ADDR_BITS-1:0]   pos_ff, pos_in;
   entry_type              entry_ff, entry_in;
   entry_type              best_ff, best_in;
   logic                   best_child_ff, best_child_in;
   logic [ADDR_BITS-1:0]   best_pos_ff, best_pos_in;
   logic [ID_BITS-1:0]     res_id_ff, res_id_in;
   logic [KEY_BITS-1:0]    res_key_ff, res_key_in;
   logic [STATUS_BITS-1:0] res_status_ff, res_status_in;

   // Response registers.
   logic [ID_BITS-1:0]     out_id_ff, out_id_in;
   logic [KEY_BITS-1:0]    out_key_ff, out_key_in;
   logic [STATUS_BITS-1:0] out_status_ff, out_status_in;
   logic [COUNT_BITS-1:0]  out_count_ff, out_count_in;

   // RAM port signals.
   logic                   ram_wr_en;
   logic [ADDR_BITS-1:0]   ram_wr_addr;
   entry_type              ram_wr_data;
   logic [ADDR_BITS-1:0]   ram_rd_addr;
   logic [ENTRY_BITS-1:0]  ram_rd_data;
   entry_type              rd_entry;

   // Shared key comparator.
   logic [KEY_BITS-1:0]    cmp_a, cmp_b;
   logic                   cmp_lt;

   // Address arithmetic around the current position.
   logic [ADDR_BITS-1:0]   parent_addr;
   logic [CHILD_BITS-1:0]  left_addr, right_addr, count_wide;
   logic                   left_ok, right_ok;
   logic                   req_accept, rsp_free, heap_full, heap_empty;

   mhpq_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (CAPACITY)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_entry = entry_type'(ram_rd_data);

   // Handshake and status flags.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign heap_full  = (count_ff == COUNT_BITS'(CAPACITY));
   assign heap_empty = (count_ff == '0);

   // Parent and child positions of the hole.
   assign parent_addr = (pos_ff - 1'b1) >> 1;
   assign left_addr   = {1'b0, pos_ff, 1'b1};
   assign right_addr  = left_addr + 1'b1;
   assign count_wide  = CHILD_BITS'(count_ff);
   assign left_ok     = (left_addr < count_wide);
   assign right_ok    = (right_addr < count_wide);

   // The one comparator used by every sift step.
   assign cmp_lt = (cmp_a < cmp_b);

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_action == ACTION_PUSH) begin
                  state_in = heap_full ? ST_DONE : ST_PU_CHK;
               end else begin
                  state_in = heap_empty ? ST_DONE : ST_PO_ROOT;
               end
            end
         end
         ST_PU_CHK:   state_in = (pos_ff == '0) ? ST_DONE : ST_PU_CMP;
         ST_PU_CMP:   state_in = cmp_lt ? ST_PU_CHK : ST_DONE;
         ST_PO_ROOT:  state_in = ST_PO_LAST;
         ST_PO_LAST:  state_in = heap_empty ? ST_DONE : ST_PO_CHK;
         ST_PO_CHK:   state_in = left_ok ? ST_PO_LEFT : ST_DONE;
         ST_PO_LEFT:  state_in = right_ok ? ST_PO_RIGHT : ST_PO_MOVE;
         ST_PO_RIGHT: state_in = ST_PO_MOVE;
         ST_PO_MOVE:  state_in = best_child_ff ? ST_PO_CHK : ST_DONE;
         ST_DONE:     state_in = rsp_free ? ST_IDLE : ST_DONE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath and RAM control for each state.
   always_comb begin
      count_in      = count_ff;
      pos_in        = pos_ff;
      entry_in      = entry_ff;
      best_in       = best_ff;
      best_child_in = best_child_ff;
      best_pos_in   = best_pos_ff;
      res_id_in     = res_id_ff;
      res_key_in    = res_key_ff;
      res_status_in = res_status_ff;
      out_id_in     = out_id_ff;
      out_key_in    = out_key_ff;
      out_status_in = out_status_ff;
      out_count_in  = out_count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = pos_ff;
      ram_wr_data   = entry_ff;
      ram_rd_addr   = '0;
      cmp_a         = entry_ff.key;
      cmp_b         = rd_entry.key;

      unique case (state_ff)
         ST_IDLE: begin
            // The root is read here so a pop finds it in the next cycle.
            if (req_accept) begin
               res_id_in  = '0;
               res_key_in = '0;
               if (req_action == ACTION_PUSH) begin
                  if (heap_full) begin
                     res_status_in = STATUS_PUSH_FULL;
                  end else begin
                     res_status_in = STATUS_OK;
                     entry_in.id   = req_item_id;
                     entry_in.key  = req_key;
                     pos_in        = count_ff[ADDR_BITS-1:0];
                     count_in      = count_ff + 1'b1;
                  end
               end else begin
                  if (heap_empty) begin
                     res_status_in = STATUS_POP_EMPTY;
                  end else begin
                     res_status_in = STATUS_OK;
                     count_in      = count_ff - 1'b1;
                  end
               end
            end
         end
         ST_PU_CHK: begin
            // At the root the new entry settles; otherwise fetch the parent.
            if (pos_ff == '0) begin
               ram_wr_en = 1'b1;
            end else begin
               ram_rd_addr = parent_addr;
            end
         end
         ST_PU_CMP: begin
            // A strictly smaller key moves the parent down into the hole.
            if (cmp_lt) begin
               ram_wr_en   = 1'b1;
               ram_wr_data = rd_entry;
               pos_in      = parent_addr;
            end else begin
               ram_wr_en = 1'b1;
            end
         end
         ST_PO_ROOT: begin
            // Capture the minimum and fetch the last entry.
            res_id_in   = rd_entry.id;
            res_key_in  = rd_entry.key;
            ram_rd_addr = count_ff[ADDR_BITS-1:0];
         end
         ST_PO_LAST: begin
            entry_in = rd_entry;
            pos_in   = '0;
         end
         ST_PO_CHK: begin
            // Without a left child the moving entry settles in the hole.
            if (left_ok) begin
               ram_rd_addr = left_addr[ADDR_BITS-1:0];
            end else begin
               ram_wr_en = 1'b1;
            end
         end
         ST_PO_LEFT: begin
            // Left child against the moving entry.
            cmp_a = rd_entry.key;
            cmp_b = entry_ff.key;
            if (cmp_lt) begin
               best_in       = rd_entry;
               best_child_in = 1'b1;
               best_pos_in   = left_addr[ADDR_BITS-1:0];
            end else begin
               best_in       = entry_ff;
               best_child_in = 1'b0;
            end
            if (right_ok) begin
               ram_rd_addr = right_addr[ADDR_BITS-1:0];
            end
         end
         ST_PO_RIGHT: begin
            // Right child against the best so far.
            cmp_a = rd_entry.key;
            cmp_b = best_ff.key;
            if (cmp_lt) begin
               best_in       = rd_entry;
               best_child_in = 1'b1;
               best_pos_in   = right_addr[ADDR_BITS-1:0];
            end
         end
         ST_PO_MOVE: begin
            // Pull the smaller child up, or settle the moving entry.
            ram_wr_en = 1'b1;
            if (best_child_ff) begin
               ram_wr_data = best_ff;
               pos_in      = best_pos_ff;
            end
         end
         ST_DONE: begin
            // Load the response once the output register is free.
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               out_id_in     = res_id_ff;
               out_key_in    = res_key_ff;
               out_status_in = res_status_ff;
               out_count_in  = count_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      entry_ff      <= entry_in;
      best_ff       <= best_in;
      best_child_ff <= best_child_in;
      best_pos_ff   <= best_pos_in;
      res_id_ff     <= res_id_in;
      res_key_ff    <= res_key_in;
      res_status_ff <= res_status_in;
      out_id_ff     <= out_id_in;
      out_key_ff    <= out_key_in;
      out_status_ff <= out_status_in;
      out_count_ff  <= out_count_in;
   end

   // Response outputs.
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_id      = out_id_ff;
   assign rsp_out_key     = out_key_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_count_after = out_count_ff;
   assign rsp_now_empty   = (out_count_ff == '0);

endmodule

`default_nettype wire

// ===== verif/tb_min_heap_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// Min-heap priority queue core testbench
// Drives push and pop beats into the queue in random bursts while the
// response side stalls on its own changing pattern. A mirror of the heap
// predicts every response beat, and the response beats are checked in order,
// field by field. The run fills the queue past capacity, drains it past
// empty, and then runs mixed segments with many equal keys.
// ----------------------------------------------------------------------------

module tb_min_heap_priority_queue_core;
   timeunit 1ns;
   timeprecision 1ps;

   import mhpq_pkg::*;

   localparam int RANDOM_ITEMS   = 1800;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 60;

   // Expected content of one response beat.
   typedef struct {
      logic [ID_BITS-1:0]     id;
      logic [KEY_BITS-1:0]    key;
      logic [STATUS_BITS-1:0] status;
      logic [COUNT_BITS-1:0]  count;
      logic                   now_empty;
   } heap_result_type;

   // Software copy of the heap that predicts each response beat.
   class heap_mirror;
      logic [ID_BITS-1:0]  ids[CAPACITY];
      logic [KEY_BITS-1:0] keys[CAPACITY];
      int unsigned         held;
      heap_result_type     due_results[$];
      int                  mismatches;

      function new();
         held = 0;
         mismatches = 0;
      endfunction

      function void swap_slots(int unsigned a, int unsigned b);
         logic [ID_BITS-1:0]  tmp_id;
         logic [KEY_BITS-1:0] tmp_key;
         tmp_id  = ids[a];
         tmp_key = keys[a];
         ids[a]  = ids[b];
         keys[a] = keys[b];
         ids[b]  = tmp_id;
         keys[b] = tmp_key;
      endfunction

      // A new entry climbs while its key is strictly below its parent's.
      function void float_up(int unsigned slot);
         int unsigned parent;
         while (slot > 0) begin
            parent = (slot - 1) / 2;
            if (keys[slot] >= keys[parent]) break;
            swap_slots(slot, parent);
            slot = parent;
         end
      endfunction

      // The moved root descends toward a strictly smaller child.
      function void sink_root();
         int unsigned slot;
         int unsigned left;
         int unsigned right;
         int unsigned best;
         slot = 0;
         while (1) begin
            left  = 2 * slot + 1;
            right = 2 * slot + 2;
            best  = slot;
            if (left < held && keys[left] < keys[best]) best = left;
            if (right < held && keys[right] < keys[best]) best = right;
            if (best == slot) break;
            swap_slots(slot, best);
            slot = best;
         end
      endfunction

      function int pending();
         return due_results.size();
      endfunction

      // Apply one accepted request beat and queue the response it causes.
      function void log_request(logic act, logic [ID_BITS-1:0] id,
                                logic [KEY_BITS-1:0] key);
         heap_result_type r;
         r.id     = '0;
         r.key    = '0;
         r.status = STATUS_OK;
         if (act == ACTION_PUSH) begin
            if (held >= CAPACITY) begin
               r.status = STATUS_PUSH_FULL;
            end else begin
               ids[held]  = id;
               keys[held] = key;
               held++;
               float_up(held - 1);
            end
         end else begin
            if (held == 0) begin
               r.status = STATUS_POP_EMPTY;
            end else begin
               r.id  = ids[0];
               r.key = keys[0];
               held--;
               ids[0]  = ids[held];
               keys[0] = keys[held];
               sink_root();
            end
         end
         r.count     = COUNT_BITS'(held);
         r.now_empty = (held == 0);
         due_results.push_back(r);
      endfunction

      // Compare one accepted response beat with the oldest prediction.
      function void check_response(logic [ID_BITS-1:0] got_id,
                                   logic [KEY_BITS-1:0] got_key,
                                   logic [STATUS_BITS-1:0] got_status,
                                   logic [COUNT_BITS-1:0] got_count,
                                   logic got_empty);
         heap_result_type want;
         if (due_results.size() == 0) begin
            $error("response beat with no request outstanding");
            mismatches++;
            return;
         end
         want = due_results.pop_front();
         if (got_id !== want.id) begin
            $error("out_id: expected %0d, actual %0d", want.id, got_id);
            mismatches++;
         end
         if (got_key !== want.key) begin
            $error("out_key: expected %h, actual %h", want.key, got_key);
            mismatches++;
         end
         if (got_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got_status);
            mismatches++;
         end
         if (got_count !== want.count) begin
            $error("count_after: expected %0d, actual %0d", want.count, got_count);
            mismatches++;
         end
         if (got_empty !== want.now_empty) begin
            $error("now_empty: expected %0d, actual %0d", want.now_empty, got_empty);
            mismatches++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_action = ACTION_PUSH;
   logic [ID_BITS-1:0]     req_item_id = '0;
   logic [KEY_BITS-1:0]    req_key = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [ID_BITS-1:0]     rsp_out_id;
   logic [KEY_BITS-1:0]    rsp_out_key;
   logic [STATUS_BITS-1:0] rsp_status;
   logic [COUNT_BITS-1:0]  rsp_count_after;
   logic                   rsp_now_empty;

   heap_mirror book = new();

   int burst_left = 1;
   int stall_mode = 0;
   int mode_left  = 100;
   int run_left   = 0;
   int idle_count = 0;

   min_heap_priority_queue_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_item_id     (req_item_id),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_id      (rsp_out_id),
      .rsp_out_key     (rsp_out_key),
      .rsp_status      (rsp_status),
      .rsp_count_after (rsp_count_after),
      .rsp_now_empty   (rsp_now_empty)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Keys lean toward a few small values so that equal keys meet often.
   function automatic logic [KEY_BITS-1:0] pick_key();
      case ($urandom_range(0, 3))
         0: return KEY_BITS'($urandom_range(0, 7));
         1: begin
            case ($urandom_range(0, 4))
               0: return '0;
               1: return '1;
               2: return 32'h7fff_ffff;
               3: return 32'h8000_0000;
               default: return 32'h0001_0000;
            endcase
         end
         default: return $urandom();
      endcase
   endfunction

   // Hold one request beat until it is accepted, then note it.
   task automatic send_beat(input logic act, input logic [ID_BITS-1:0] id,
                            input logic [KEY_BITS-1:0] key);
      req_valid   <= 1'b1;
      req_action  <= act;
      req_item_id <= id;
      req_key     <= key;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.log_request(act, id, key);
   endtask

   // Send one beat as part of a burst; a gap follows when the burst ends.
   task automatic pace_send(input logic act, input logic [ID_BITS-1:0] id,
                            input logic [KEY_BITS-1:0] key);
      send_beat(act, id, key);
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 10);
      end
   endtask

   // Stop sending until every outstanding response beat has arrived.
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (book.pending() != 0);
   endtask

   // Response side: stall pattern changes mode now and then; accepted beats
   // are checked against the mirror.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         book.check_response(rsp_out_id, rsp_out_key, rsp_status,
                             rsp_count_after, rsp_now_empty);
      end
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         mode_left  <= $urandom_range(64, 512);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 7) == 0);
         2: rsp_stall <= $urandom_range(0, 1);
         default: begin
            if (run_left == 0) begin
               rsp_stall <= ~rsp_stall;
               run_left  <= $urandom_range(1, 24);
            end else begin
               run_left <= run_left - 1;
            end
         end
      endcase
   end

   // Watchdog on stretches with no beat accepted on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_count <= 0;
      end else begin
         idle_count <= idle_count + 1;
         if (idle_count >= WATCHDOG_LIMIT) begin
            $display("tb_min_heap_priority_queue_core failed");
            $finish;
         end
      end
   end

   initial begin
      int  sent;
      int  seg_len;
      int  push_odds;
      logic act;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: pop on empty, extreme ids and keys, equal keys, then
      // drain past empty.
      pace_send(ACTION_POP, 8'hff, '1);
      pace_send(ACTION_PUSH, 8'hff, '1);
      pace_send(ACTION_PUSH, 8'h00, '0);
      pace_send(ACTION_PUSH, 8'h01, '0);
      pace_send(ACTION_PUSH, 8'h02, 32'h0001_0000);
      pace_send(ACTION_PUSH, 8'h03, '1);
      pace_send(ACTION_PUSH, 8'haa, 32'h5555_5555);
      pace_send(ACTION_PUSH, 8'h55, 32'haaaa_aaaa);
      pace_send(ACTION_PUSH, 8'h04, '0);
      repeat (9) pace_send(ACTION_POP, 8'h00, '0);
      drain_responses();

      // Fill the queue to capacity, then push into the full queue.
      sent = 0;
      while (book.held < CAPACITY) begin
         act = ($urandom_range(0, 19) == 0) ? ACTION_POP : ACTION_PUSH;
         pace_send(act, ID_BITS'($urandom_range(0, 255)), pick_key());
         sent++;
      end
      repeat (4) begin
         pace_send(ACTION_PUSH, ID_BITS'($urandom_range(0, 255)), pick_key());
         sent++;
      end
      drain_responses();

      // Drain to empty, then pop the empty queue a few times.
      while (book.held > 0) begin
         act = ($urandom_range(0, 19) == 0) ? ACTION_PUSH : ACTION_POP;
         pace_send(act, ID_BITS'($urandom_range(0, 255)), pick_key());
         sent++;
      end
      repeat (3) begin
         pace_send(ACTION_POP, ID_BITS'($urandom_range(0, 255)), pick_key());
         sent++;
      end
      drain_responses();

      // Mixed segments that lean toward growth, shrinkage or balance.
      while (sent < RANDOM_ITEMS) begin
         seg_len = $urandom_range(40, 200);
         case ($urandom_range(0, 2))
            0: push_odds = 25;
            1: push_odds = 50;
            default: push_odds = 75;
         endcase
         repeat (seg_len) begin
            act = ($urandom_range(0, 99) < push_odds) ? ACTION_PUSH : ACTION_POP;
            pace_send(act, ID_BITS'($urandom_range(0, 255)), pick_key());
            sent++;
         end
         if ($urandom_range(0, 2) == 0) drain_responses();
      end

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (book.mismatches == 0 && book.pending() == 0) begin
         $display("tb_min_heap_priority_queue_core passed");
      end else begin
         $display("tb_min_heap_priority_queue_core failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/mhpq_pkg.sv
sv/mhpq_ram.sv
sv/min_heap_priority_queue_core.sv
verif/tb_min_heap_priority_queue_core.sv
